/* rtl/core/gear_pair_ratio_checker_assert.svh */
// ---------------------------------------------------------------------------
// Gear pair ratio checker assertion macros
// Shared concurrent assertion forms. Every user has clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef GEAR_PAIR_RATIO_CHECKER_ASSERT_SVH
`define GEAR_PAIR_RATIO_CHECKER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define GPRC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define GPRC_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/gprc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gear pair ratio checker package
// Types, codes and fixed widths shared by the checker modules.
// ---------------------------------------------------------------------------
package gprc_pkg;

	// Fixed field widths
	localparam int DR_W     = 24;
	localparam int TOL_W    = 24;
	localparam int RATIO_W  = 24;
	localparam int ERR_W    = 32;
	localparam int MAG_W    = 31;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_MIN_TEETH     = 2'd0;
	localparam logic [1:0] REG_MAX_TEETH     = 2'd1;
	localparam logic [1:0] REG_DESIRED_RATIO = 2'd2;
	localparam logic [1:0] REG_ALLOWED_ERROR = 2'd3;

	localparam int             MIN_TEETH_RST     = 15;
	localparam int             MAX_TEETH_RST     = 100;
	localparam logic [DR_W-1:0]  DESIRED_RATIO_RST = 24'd166461;
	localparam logic [TOL_W-1:0] ALLOWED_ERROR_RST = 24'd32768;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_ACCEPT     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OUT_TOL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SKIP       = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_INT_TARGET = 2'd3;

	// Saturation limit of the error magnitude
	localparam logic [MAG_W-1:0] ERR_CAP = 31'h7FFF_FFFF;

	// Percent scale applied to the difference
	localparam logic [6:0] PCT_SCALE = 7'd100;

	localparam int QUEUE_DEPTH = 2;

	// How the front classified a pair
	typedef enum logic [1:0] {
		KIND_CALC = 2'd0,
		KIND_SKIP = 2'd1,
		KIND_INT  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  restart;
	} ctrl_t;

endpackage

/* rtl/core/gprc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gear pair ratio checker front end
// Takes requests, classifies each pair against the configuration and
// hands it to the queue.
// ---------------------------------------------------------------------------
module gprc_front #(
	parameter int TEETH_BITS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [TEETH_BITS-1:0]         in_a,
	input  logic [TEETH_BITS-1:0]         in_b,
	input  logic                          in_restart,
	input  logic [TEETH_BITS-1:0]         min_teeth,
	input  logic [TEETH_BITS-1:0]         max_teeth,
	input  logic [gprc_pkg::DR_W-1:0]     desired_ratio,
	output logic                          push,
	input  logic                          full,
	output logic [TEETH_BITS-1:0]         out_a,
	output logic [TEETH_BITS-1:0]         out_b,
	output gprc_pkg::ctrl_t               out_ctrl
);

	logic                  valid_s1;
	logic [TEETH_BITS-1:0] a_s1;
	logic [TEETH_BITS-1:0] b_s1;
	gprc_pkg::ctrl_t       ctrl_s1;
	gprc_pkg::ctrl_t       ctrl_in;
	logic                  skip;
	logic                  int_target;
	logic                  take;

	assign int_target = (desired_ratio[FRAC_BITS-1:0] == '0);
	assign skip = (in_a == in_b) || (in_b == '0) ||
		(in_a < min_teeth) || (in_a > max_teeth) ||
		(in_b < min_teeth) || (in_b > max_teeth);

	always_comb begin
		ctrl_in.restart = in_restart;
		if (int_target) begin
			ctrl_in.kind = gprc_pkg::KIND_INT;
		end else if (skip) begin
			ctrl_in.kind = gprc_pkg::KIND_SKIP;
		end else begin
			ctrl_in.kind = gprc_pkg::KIND_CALC;
		end
	end

	assign push     = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_s1    <= in_a;
			b_s1    <= in_b;
			ctrl_s1 <= ctrl_in;
		end
	end

	assign out_a    = a_s1;
	assign out_b    = b_s1;
	assign out_ctrl = ctrl_s1;

endmodule

/* rtl/core/gprc_fifo.sv */
`timescale 1ns / 1ps
`include "gear_pair_ratio_checker_assert.svh"
// ---------------------------------------------------------------------------
// Gear pair ratio checker queue
// Two-entry queue in flip-flops between the front and back ends.
// ---------------------------------------------------------------------------
module gprc_fifo #(
	parameter int W = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = $clog2(gprc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gprc_pkg::QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [gprc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(gprc_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`GPRC_ASSERT(a_no_push_full, !(push && full), "queue written while full")
	`GPRC_ASSERT(a_no_pop_empty, !(pop && empty), "queue read while empty")
	`GPRC_ASSERT_NEXT(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(gprc_pkg::QUEUE_DEPTH), "queue count overrun")

endmodule

/* rtl/core/gprc_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gear pair ratio checker divider
// Radix-2 restoring divider, one quotient bit per cycle. The dividend is
// left aligned and the quotient is held after the last step.
// ---------------------------------------------------------------------------
module gprc_div #(
	parameter int NW = 40,
	parameter int DW = 32,
	parameter int CW = $clog2(NW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] rem_init,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [CW-1:0] steps,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] dvd_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   trial;
	logic [DW:0]   trial_sub;
	logic          ge;

	assign trial     = {rem_q, dvd_q[NW-1]};
	assign ge        = (trial >= {1'b0, dsr_q});
	assign trial_sub = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/gprc_back.sv */
`timescale 1ns / 1ps
`include "gear_pair_ratio_checker_assert.svh"
// ---------------------------------------------------------------------------
// Gear pair ratio checker back end
// Computes ratio and percent error with two dividers, keeps the running
// best error and accepted count, and holds the result register.
// ---------------------------------------------------------------------------
module gprc_back #(
	parameter int TEETH_BITS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	output logic                             q_pop,
	input  logic [TEETH_BITS-1:0]            q_a,
	input  logic [TEETH_BITS-1:0]            q_b,
	input  gprc_pkg::ctrl_t                  q_ctrl,
	input  logic [gprc_pkg::DR_W-1:0]        desired_ratio,
	input  logic [gprc_pkg::TOL_W-1:0]       allowed_error,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [gprc_pkg::STATUS_W-1:0]    res_status,
	output logic [gprc_pkg::RATIO_W-1:0]     res_ratio,
	output logic [gprc_pkg::ERR_W-1:0]       res_error,
	output logic [gprc_pkg::COUNT_W-1:0]     res_count,
	output logic                             res_new_best
);

	localparam int NUM_W = TEETH_BITS + FRAC_BITS;
	localparam int DEN_W = gprc_pkg::DR_W + TEETH_BITS;
	localparam int SCL_W = DEN_W + 7;
	localparam int NF_W  = SCL_W + FRAC_BITS;
	localparam int R0_W  = NF_W - gprc_pkg::MAG_W;
	localparam int QW    = (NUM_W > gprc_pkg::MAG_W) ? NUM_W : gprc_pkg::MAG_W;
	localparam int CW    = $clog2(QW + 1);
	localparam int MAG_W = gprc_pkg::MAG_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_DIFF  = 7'b0000100,
		ST_SCALE = 7'b0001000,
		ST_ECHK  = 7'b0010000,
		ST_WAIT  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [TEETH_BITS-1:0]           a_q;
	logic [TEETH_BITS-1:0]           b_q;
	gprc_pkg::kind_t                 kind_q;
	logic [DEN_W-1:0]                den_q;
	logic [DEN_W-1:0]                diff_q;
	logic                            neg_q;
	logic [SCL_W-1:0]                scl_q;
	logic                            sat_q;
	logic [gprc_pkg::ERR_W-1:0]      best_q;
	logic [gprc_pkg::COUNT_W-1:0]    cnt_q;
	logic                            res_valid_q;

	logic [NUM_W-1:0]                num;
	logic [DEN_W-1:0]                num_ext;
	logic [NF_W-1:0]                 nfull;
	logic [R0_W-1:0]                 r0;
	logic                            sat_n;
	logic                            rstart;
	logic                            estart;
	logic                            rbusy;
	logic                            ebusy;
	logic [QW-1:0]                   rquo;
	logic [QW-1:0]                   equo;
	logic [MAG_W-1:0]                mag;
	logic                            calc;
	logic                            in_tol;
	logic                            acc;
	logic                            better;
	logic                            flag;
	logic                            load;
	logic [gprc_pkg::STATUS_W-1:0]   status_n;
	logic [gprc_pkg::COUNT_W-1:0]    cnt_n;
	logic [gprc_pkg::ERR_W-1:0]      err_n;

	assign num     = {a_q, {FRAC_BITS{1'b0}}};
	assign num_ext = DEN_W'(num);
	assign nfull   = {scl_q, {FRAC_BITS{1'b0}}};
	assign r0      = nfull[NF_W-1:MAG_W];
	// Quotient cannot fit the magnitude when the dividend's top part reaches
	// the divisor.
	assign sat_n   = ({{DEN_W{1'b0}}, r0} >= {{R0_W{1'b0}}, den_q});

	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign rstart = (state_q == ST_MUL);
	assign estart = (state_q == ST_ECHK) && !sat_n;

	gprc_div #(
		.NW (QW),
		.DW (TEETH_BITS),
		.CW (CW)
	) u_ratio_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rstart),
		.rem_init ({TEETH_BITS{1'b0}}),
		.dividend (QW'(num) << (QW - NUM_W)),
		.divisor  (b_q),
		.steps    (CW'(NUM_W)),
		.busy     (rbusy),
		.quotient (rquo)
	);

	gprc_div #(
		.NW (QW),
		.DW (DEN_W),
		.CW (CW)
	) u_error_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (estart),
		.rem_init (DEN_W'(r0)),
		.dividend (QW'(nfull[MAG_W-1:0]) << (QW - MAG_W)),
		.divisor  (den_q),
		.steps    (CW'(MAG_W)),
		.busy     (ebusy),
		.quotient (equo)
	);

	always_comb begin
		mag    = sat_q ? gprc_pkg::ERR_CAP : equo[MAG_W-1:0];
		calc   = (kind_q == gprc_pkg::KIND_CALC);
		in_tol = ({1'b0, mag} <= (MAG_W + 1)'(allowed_error));
		acc    = calc && in_tol;
		better = ({1'b0, mag} < best_q);
		flag   = acc && better;
		cnt_n  = (acc && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
		if (!calc) begin
			err_n = '0;
		end else if (neg_q) begin
			err_n = '0 - {1'b0, mag};
		end else begin
			err_n = {1'b0, mag};
		end
		case (kind_q)
			gprc_pkg::KIND_INT:  status_n = gprc_pkg::STATUS_INT_TARGET;
			gprc_pkg::KIND_SKIP: status_n = gprc_pkg::STATUS_SKIP;
			default:             status_n = in_tol ? gprc_pkg::STATUS_ACCEPT :
				gprc_pkg::STATUS_OUT_TOL;
		endcase
	end

	assign load = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			best_q      <= '1;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_ctrl.restart) begin
							best_q <= '1;
							cnt_q  <= '0;
						end
						state_q <= (q_ctrl.kind == gprc_pkg::KIND_CALC) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL:   state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ECHK;
				ST_ECHK:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!rbusy && !ebusy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						cnt_q <= cnt_n;
						if (flag) begin
							best_q <= {1'b0, mag};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			a_q    <= q_a;
			b_q    <= q_b;
			kind_q <= q_ctrl.kind;
		end
		if (state_q == ST_MUL) begin
			den_q <= DEN_W'(desired_ratio) * DEN_W'(b_q);
		end
		if (state_q == ST_DIFF) begin
			neg_q  <= (num_ext < den_q);
			diff_q <= (num_ext < den_q) ? den_q - num_ext : num_ext - den_q;
		end
		if (state_q == ST_SCALE) begin
			scl_q <= SCL_W'(diff_q) * SCL_W'(gprc_pkg::PCT_SCALE);
		end
		if (state_q == ST_ECHK) begin
			sat_q <= sat_n;
		end
		if (load) begin
			res_status   <= status_n;
			res_ratio    <= calc ? rquo[gprc_pkg::RATIO_W-1:0] : '0;
			res_error    <= err_n;
			res_count    <= cnt_n;
			res_new_best <= flag;
		end
	end

	assign res_valid = res_valid_q;

	`GPRC_ASSERT(a_best_needs_accept, !(load && flag && (status_n != gprc_pkg::STATUS_ACCEPT)), "new best flagged on a pair that was not accepted")
	`GPRC_ASSERT_NEXT(a_wait_exit, (state_q == ST_WAIT) && !rbusy && !ebusy, state_q == ST_DONE, "back end stuck after both divisions ended")
	`GPRC_ASSERT_NEXT(a_count_holds_max, load && (cnt_q == '1), cnt_q == '1, "accepted count wrapped past its maximum")

endmodule

/* rtl/core/gear_pair_ratio_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gear pair ratio checker
// Checks candidate gear pairs against a tooth range and a desired ratio,
// reports ratio and percent error, and tracks accepted pairs and best error.
// ---------------------------------------------------------------------------
//
//  Channel   | Role          | Payload
//  ----------+---------------+---------------------------------------------
//  s_axis_*  | pair requests | tdata: teeth_a, teeth_b; tuser: restart
//  m_axis_*  | results       | tdata: ratio_q16, error_pct_q16,
//            |               |        solution_count; tuser: status, new_best
//  APB       | configuration | min_teeth, max_teeth, desired_ratio_q16,
//            |               | allowed_error_q16 at byte addresses 0, 4, 8, 12
//
// For a computed pair the result passes through the input stage and the queue,
// then the multiply, subtract, scale and saturation check states, the 31-step
// error division, the wait state and finally the result register. The ratio
// division (TEETH_BITS + FRAC_BITS steps) starts with the multiply and runs
// alongside; the wait state ends once both divisions are done.
// The back end takes a new pair only after the last one has left the done
// state. A skipped pair or an integer target goes straight from the idle
// state to the done state.
// The request side keeps taking pairs while a result waits, through an input
// stage and a two-entry queue; the back end stalls only on its result
// register.
// Reset is asynchronous and active low; the configuration returns to its
// documented defaults, the best error is set to its maximum and the count is cleared.
//
// The front end classifies each request as it comes in: integer target,
// skipped pair, or a pair to be worked out. Configuration must only be written
// by the user while the block is idle (the block does not enforce it), so doing the range check early is safe.
// The back end pulls from the queue, applies a restart, then multiplies the
// desired ratio by the driven tooth count, forms the magnitude of the
// difference and scales it by one hundred. The ratio division starts with the
// multiply and the error division after the scaling; they run side by side on
// two restoring dividers. When the top part of the scaled difference already
// reaches the divisor the error is saturated and the error division is not started.
// ---------------------------------------------------------------------------
module gear_pair_ratio_checker #(
	parameter int TEETH_BITS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Request channel
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [TEETH_BITS-1:0] teeth_a, [2*TEETH_BITS-1:TEETH_BITS] teeth_b, zero pad
	input  logic [((2*TEETH_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// [0] restart
	input  logic [0:0]                           s_axis_tuser,
	// Result channel
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [23:0] ratio_q16, [55:24] error_pct_q16, [71:56] solution_count
	output logic [71:0]                          m_axis_tdata,
	// [1:0] status, [2] new_best
	output logic [2:0]                           m_axis_tuser,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gprc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [gprc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [gprc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int QD_W = 2 * TEETH_BITS + $bits(gprc_pkg::ctrl_t);

	logic [TEETH_BITS-1:0]             min_teeth_q;
	logic [TEETH_BITS-1:0]             max_teeth_q;
	logic [gprc_pkg::DR_W-1:0]         desired_ratio_q;
	logic [gprc_pkg::TOL_W-1:0]        allowed_error_q;
	logic                              cfg_wr;
	logic [1:0]                        cfg_idx;

	logic                              push;
	logic                              full;
	logic                              pop;
	logic                              empty;
	logic [TEETH_BITS-1:0]             f_a;
	logic [TEETH_BITS-1:0]             f_b;
	gprc_pkg::ctrl_t                   f_ctrl;
	logic [QD_W-1:0]                   q_wdata;
	logic [QD_W-1:0]                   q_rdata;
	gprc_pkg::ctrl_t                   q_ctrl;

	logic [gprc_pkg::STATUS_W-1:0]     res_status;
	logic [gprc_pkg::RATIO_W-1:0]      res_ratio;
	logic [gprc_pkg::ERR_W-1:0]        res_error;
	logic [gprc_pkg::COUNT_W-1:0]      res_count;
	logic                              res_new_best;

	// Configuration registers. The port never waits.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_teeth_q     <= TEETH_BITS'(gprc_pkg::MIN_TEETH_RST);
			max_teeth_q     <= TEETH_BITS'(gprc_pkg::MAX_TEETH_RST);
			desired_ratio_q <= gprc_pkg::DESIRED_RATIO_RST;
			allowed_error_q <= gprc_pkg::ALLOWED_ERROR_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				gprc_pkg::REG_MIN_TEETH:     min_teeth_q     <= pwdata[TEETH_BITS-1:0];
				gprc_pkg::REG_MAX_TEETH:     max_teeth_q     <= pwdata[TEETH_BITS-1:0];
				gprc_pkg::REG_DESIRED_RATIO: desired_ratio_q <= pwdata[gprc_pkg::DR_W-1:0];
				gprc_pkg::REG_ALLOWED_ERROR: allowed_error_q <= pwdata[gprc_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			gprc_pkg::REG_MIN_TEETH:     prdata = gprc_pkg::CFG_DATA_W'(min_teeth_q);
			gprc_pkg::REG_MAX_TEETH:     prdata = gprc_pkg::CFG_DATA_W'(max_teeth_q);
			gprc_pkg::REG_DESIRED_RATIO: prdata = gprc_pkg::CFG_DATA_W'(desired_ratio_q);
			gprc_pkg::REG_ALLOWED_ERROR: prdata = gprc_pkg::CFG_DATA_W'(allowed_error_q);
			default:                     prdata = '0;
		endcase
	end

	// Front end: takes requests and classifies them.
	gprc_front #(
		.TEETH_BITS (TEETH_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_a          (s_axis_tdata[TEETH_BITS-1:0]),
		.in_b          (s_axis_tdata[2*TEETH_BITS-1:TEETH_BITS]),
		.in_restart    (s_axis_tuser[0]),
		.min_teeth     (min_teeth_q),
		.max_teeth     (max_teeth_q),
		.desired_ratio (desired_ratio_q),
		.push          (push),
		.full          (full),
		.out_a         (f_a),
		.out_b         (f_b),
		.out_ctrl      (f_ctrl)
	);

	assign q_wdata = {f_ctrl, f_b, f_a};

	// Queue between the two halves, so each can stall on its own.
	gprc_fifo #(
		.W (QD_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty)
	);

	assign q_ctrl = q_rdata[QD_W-1:2*TEETH_BITS];

	// Back end: arithmetic, running state and the result register.
	gprc_back #(
		.TEETH_BITS (TEETH_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (empty),
		.q_pop         (pop),
		.q_a           (q_rdata[TEETH_BITS-1:0]),
		.q_b           (q_rdata[2*TEETH_BITS-1:TEETH_BITS]),
		.q_ctrl        (q_ctrl),
		.desired_ratio (desired_ratio_q),
		.allowed_error (allowed_error_q),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_status    (res_status),
		.res_ratio     (res_ratio),
		.res_error     (res_error),
		.res_count     (res_count),
		.res_new_best  (res_new_best)
	);

	assign m_axis_tdata = {res_count, res_error, res_ratio};
	assign m_axis_tuser = {res_new_best, res_status};

endmodule
